// ===== design/lhp_pkg.sv =====
// shared types and constants for the latency histogram percentile core
`timescale 1ns / 1ps

package lhp_pkg;

   localparam int PCT_W     = 10;
   localparam int SLOT_W    = 3;
   localparam int CSR_IDX_W = 3;
   localparam int DATA_W    = 32;
   localparam int NUM_REGS  = 5;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_PCT_SLOT0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PCT_SLOT4 = 3'd4;

   localparam logic [PCT_W-1:0] PCT_RESET [NUM_REGS] = '{
      10'd200, 10'd500, 10'd900, 10'd990, 10'd999
   };

   // operation codes
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [DATA_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] pct_value;
      logic [DATA_W-1:0] pct_samples;
      logic [DATA_W-1:0] min_latency;
      logic [DATA_W-1:0] max_latency;
      logic [DATA_W-1:0] total_samples;
      logic              last;
   } rsp_type;

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_IDLE  = 10'b00_0000_0010,
      ST_DRAIN = 10'b00_0000_0100,
      ST_PREP  = 10'b00_0000_1000,
      ST_READ  = 10'b00_0001_0000,
      ST_ACC   = 10'b00_0010_0000,
      ST_SCALE = 10'b00_0100_0000,
      ST_CHECK = 10'b00_1000_0000,
      ST_FILL  = 10'b01_0000_0000,
      ST_EMIT  = 10'b10_0000_0000
   } state_type;

endpackage

// ===== design/lhp_ram.sv =====
// generic single-write, single-read ram with registered read
`timescale 1ns / 1ps

module lhp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lhp_record.sv =====
// record pipeline: sample to bucket index, then read-modify-write of the bucket count
`timescale 1ns / 1ps

module lhp_record #(
   parameter int BUCKET_BITS  = 6,
   parameter int BUCKET_COUNT = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [lhp_pkg::DATA_W-1:0]      sample,
   output logic [$clog2(BUCKET_COUNT)-1:0] rd_addr,
   input  logic [lhp_pkg::DATA_W-1:0]      rd_data,
   output logic                            wr_en,
   output logic [$clog2(BUCKET_COUNT)-1:0] wr_addr,
   output logic [lhp_pkg::DATA_W-1:0]      wr_data,
   output logic                            busy
);

   localparam int IDX_W = $clog2(BUCKET_COUNT);
   localparam int RAW_W = BUCKET_BITS + 5;
   localparam int CMP_W = (RAW_W > IDX_W) ? RAW_W : IDX_W;

   // stage 1: sample held, top bit found
   logic                       v1_ff;
   logic [lhp_pkg::DATA_W-1:0] s1_ff;
   logic [4:0]                 top1;

   // stage 2: index formed, bucket read issued
   logic                       v2_ff;
   logic [lhp_pkg::DATA_W-1:0] s2_ff;
   logic [4:0]                 m2_ff;
   logic [4:0]                 e2;
   logic [lhp_pkg::DATA_W-1:0] shifted2;
   logic [RAW_W-1:0]           raw2;
   logic [CMP_W-1:0]           raw2_c;
   logic [IDX_W-1:0]           idx2;
   logic                       hit_in;

   // stage 3: count updated and written back
   logic                       v3_ff;
   logic [IDX_W-1:0]           idx3_ff;
   logic                       hit3_ff;
   logic [lhp_pkg::DATA_W-1:0] last_wd_ff;
   logic [lhp_pkg::DATA_W-1:0] base3;

   always_comb begin
      top1 = 5'd0;
      for (int b = 0; b < lhp_pkg::DATA_W; b++) begin
         if (s1_ff[b]) begin
            top1 = 5'(b);
         end
      end
   end

   always_comb begin
      e2       = m2_ff - 5'(BUCKET_BITS);
      shifted2 = s2_ff >> e2;
      if (m2_ff <= 5'(BUCKET_BITS)) begin
         raw2 = s2_ff[RAW_W-1:0];
      end else begin
         raw2 = ((RAW_W'(e2) + RAW_W'(1)) << BUCKET_BITS)
              + RAW_W'(shifted2[BUCKET_BITS-1:0]);
      end
      raw2_c = CMP_W'(raw2);
      if (raw2_c > CMP_W'(BUCKET_COUNT - 1)) begin
         idx2 = IDX_W'(BUCKET_COUNT - 1);
      end else begin
         idx2 = raw2_c[IDX_W-1:0];
      end
   end

   // the item now in stage 3 writes this cycle, so a read of the same bucket is stale
   assign hit_in = v3_ff && (idx3_ff == idx2);

   assign base3   = hit3_ff ? last_wd_ff : rd_data;
   assign rd_addr = idx2;
   assign wr_en   = v3_ff;
   assign wr_addr = idx3_ff;
   assign wr_data = base3 + lhp_pkg::DATA_W'(1);
   assign busy    = v1_ff | v2_ff | v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff   <= sample;
      s2_ff   <= s1_ff;
      m2_ff   <= top1;
      idx3_ff <= idx2;
      hit3_ff <= hit_in;
      if (v3_ff) begin
         last_wd_ff <= wr_data;
      end
   end

endmodule

// ===== design/latency_histogram_percentiles_core.sv =====
// top level: config registers, record path, bucket store and percentile walk
`timescale 1ns / 1ps

//  channel   direction  handshake                 payload
//  req       in         req_valid / req_stall     lhp_pkg::req_type
//  rsp       out        rsp_valid / rsp_stall     lhp_pkg::rsp_type
//  csr       in         csr_write_en (no wait)    csr_index, csr_wdata
//
//  after reset a clearing pass zeroes every bucket of the ram, with req stalled
//  record items enter every cycle while req is not stalled; a three-stage read-modify-write updates the bucket
//  a report drains the record pipe, forms a threshold for each active slot in turn,
//  then walks the ram bucket by bucket (accumulate, scale, compare), comparing again
//  for each further slot reached at the same bucket; req stays stalled until the last
//  result is taken, and rsp_stall holds the result register; with no active slot it ends at once, unanswered

module latency_histogram_percentiles_core #(
   parameter int BUCKET_BITS  = 6,
   parameter int BUCKET_COUNT = 1024,
   parameter int PCT_SLOTS    = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  lhp_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output lhp_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write_en,
   input  logic [lhp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lhp_pkg::PCT_W-1:0]         csr_wdata
);

   localparam int IDX_W   = $clog2(BUCKET_COUNT);
   localparam int SUM_W   = lhp_pkg::DATA_W + IDX_W;
   localparam int SCALE_W = SUM_W + 10;
   localparam int THR_W   = lhp_pkg::PCT_W + lhp_pkg::DATA_W;
   localparam int SIDX_W  = (PCT_SLOTS > 1) ? $clog2(PCT_SLOTS) : 1;

   localparam logic [IDX_W-1:0] LAST_BUCKET = IDX_W'(BUCKET_COUNT - 1);

   lhp_pkg::state_type state_ff, state_in;

   logic [lhp_pkg::PCT_W-1:0]  pct_ff [lhp_pkg::NUM_REGS];
   logic [lhp_pkg::DATA_W-1:0] min_ff, max_ff, total_ff;

   logic                       req_acc;
   logic                       rec_start;
   logic                       rec_busy;
   logic [IDX_W-1:0]           rec_rd_addr;
   logic                       rec_wr_en;
   logic [IDX_W-1:0]           rec_wr_addr;
   logic [lhp_pkg::DATA_W-1:0] rec_wr_data;

   logic                       ram_wr_en;
   logic [IDX_W-1:0]           ram_wr_addr;
   logic [lhp_pkg::DATA_W-1:0] ram_wr_data;
   logic [IDX_W-1:0]           ram_rd_addr;
   logic [lhp_pkg::DATA_W-1:0] ram_rd_data;

   logic [IDX_W-1:0]           clr_ff;
   logic [lhp_pkg::SLOT_W-1:0] len_in, len_ff;
   logic [lhp_pkg::SLOT_W-1:0] k_ff;
   logic [lhp_pkg::SLOT_W-1:0] j_ff;
   logic [lhp_pkg::SLOT_W-1:0] out_ff, out_sel;
   logic [IDX_W-1:0]           i_ff;
   logic [SUM_W-1:0]           sum_ff;
   logic [SCALE_W-1:0]         scaled_ff;
   logic [lhp_pkg::DATA_W-1:0] last_cum_ff;
   logic [THR_W-1:0]           thr_ff [PCT_SLOTS];
   logic [lhp_pkg::DATA_W-1:0] val_ff [PCT_SLOTS];
   logic [lhp_pkg::DATA_W-1:0] smp_ff [PCT_SLOTS];
   logic                       reached;
   logic                       slot_last;
   logic [lhp_pkg::DATA_W-1:0] seg_samples;
   logic                       rsp_valid_ff;
   lhp_pkg::rsp_type           rsp_ff, rsp_next;

   // midpoint of a bucket, saturating when it would not fit in 32 bits
   function automatic logic [lhp_pkg::DATA_W-1:0] mid_value(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0]         e;
      logic [BUCKET_BITS+1:0]   pat;
      logic [lhp_pkg::DATA_W-1:0] v;
      e   = (idx >> BUCKET_BITS) - IDX_W'(1);
      pat = {1'b1, BUCKET_BITS'(idx), 1'b1};
      if (lhp_pkg::DATA_W'(idx) < (lhp_pkg::DATA_W'(2) << BUCKET_BITS)) begin
         v = lhp_pkg::DATA_W'(idx);
      end else if (lhp_pkg::DATA_W'(e) + lhp_pkg::DATA_W'(BUCKET_BITS)
                   > lhp_pkg::DATA_W'(31)) begin
         v = '1;
      end else begin
         v = lhp_pkg::DATA_W'(pat) << (e - IDX_W'(1));
      end
      return v;
   endfunction

   assign req_stall = (state_ff != lhp_pkg::ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign rec_start = req_acc && (req_data.operation == lhp_pkg::OP_RECORD);

   lhp_record #(
      .BUCKET_BITS  (BUCKET_BITS),
      .BUCKET_COUNT (BUCKET_COUNT)
   ) u_record (
      .clock   (clock),
      .reset   (reset),
      .start   (rec_start),
      .sample  (req_data.sample),
      .rd_addr (rec_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_wr_addr),
      .wr_data (rec_wr_data),
      .busy    (rec_busy)
   );

   lhp_ram #(
      .WIDTH (lhp_pkg::DATA_W),
      .DEPTH (BUCKET_COUNT)
   ) u_buckets (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (state_ff == lhp_pkg::ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = rec_wr_en;
         ram_wr_addr = rec_wr_addr;
         ram_wr_data = rec_wr_data;
      end
   end

   // walk reads bucket 0 on entry, then the next bucket each time a compare misses
   always_comb begin
      if (state_ff == lhp_pkg::ST_READ) begin
         ram_rd_addr = '0;
      end else if (state_ff == lhp_pkg::ST_CHECK) begin
         ram_rd_addr = i_ff + IDX_W'(1);
      end else begin
         ram_rd_addr = rec_rd_addr;
      end
   end

   // active list is the leading nonzero slots
   always_comb begin
      logic run;
      run    = 1'b1;
      len_in = '0;
      for (int s = 0; s < PCT_SLOTS; s++) begin
         if (run && (pct_ff[s] != '0)) begin
            len_in = len_in + lhp_pkg::SLOT_W'(1);
         end else begin
            run = 1'b0;
         end
      end
   end

   assign reached     = scaled_ff >= SCALE_W'(thr_ff[j_ff[SIDX_W-1:0]]);
   assign slot_last   = (j_ff == len_ff - lhp_pkg::SLOT_W'(1));
   assign seg_samples = sum_ff[lhp_pkg::DATA_W-1:0] - last_cum_ff;

   always_comb begin
      if (!rsp_valid_ff) begin
         out_sel = out_ff;
      end else begin
         out_sel = out_ff + lhp_pkg::SLOT_W'(1);
      end
      rsp_next.slot          = out_sel;
      rsp_next.pct_value     = val_ff[out_sel[SIDX_W-1:0]];
      rsp_next.pct_samples   = smp_ff[out_sel[SIDX_W-1:0]];
      rsp_next.min_latency   = min_ff;
      rsp_next.max_latency   = max_ff;
      rsp_next.total_samples = total_ff;
      rsp_next.last          = (out_sel == len_ff - lhp_pkg::SLOT_W'(1));
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lhp_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_BUCKET) begin
               state_in = lhp_pkg::ST_IDLE;
            end
         end
         lhp_pkg::ST_IDLE: begin
            if (req_acc && (req_data.operation == lhp_pkg::OP_REPORT)) begin
               state_in = lhp_pkg::ST_DRAIN;
            end
         end
         lhp_pkg::ST_DRAIN: begin
            if (len_in == '0) begin
               state_in = lhp_pkg::ST_IDLE;
            end else if (!rec_busy) begin
               state_in = lhp_pkg::ST_PREP;
            end
         end
         lhp_pkg::ST_PREP: begin
            if (k_ff == len_ff - lhp_pkg::SLOT_W'(1)) begin
               state_in = lhp_pkg::ST_READ;
            end
         end
         lhp_pkg::ST_READ:  state_in = lhp_pkg::ST_ACC;
         lhp_pkg::ST_ACC:   state_in = lhp_pkg::ST_SCALE;
         lhp_pkg::ST_SCALE: state_in = lhp_pkg::ST_CHECK;
         lhp_pkg::ST_CHECK: begin
            priority if (reached && slot_last) begin
               state_in = lhp_pkg::ST_EMIT;
            end else if (reached) begin
               state_in = lhp_pkg::ST_CHECK;
            end else if (i_ff == LAST_BUCKET) begin
               state_in = lhp_pkg::ST_FILL;
            end else begin
               state_in = lhp_pkg::ST_ACC;
            end
         end
         lhp_pkg::ST_FILL: begin
            if (slot_last) begin
               state_in = lhp_pkg::ST_EMIT;
            end
         end
         lhp_pkg::ST_EMIT: begin
            if (rsp_valid_ff && !rsp_stall && rsp_ff.last) begin
               state_in = lhp_pkg::ST_IDLE;
            end
         end
         default: state_in = lhp_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhp_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
         total_ff     <= '0;
         for (int r = 0; r < lhp_pkg::NUM_REGS; r++) begin
            pct_ff[r] <= lhp_pkg::PCT_RESET[r];
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == lhp_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + IDX_W'(1);
         end
         if (csr_write_en && (csr_index <= lhp_pkg::CSR_PCT_SLOT4)) begin
            pct_ff[csr_index] <= csr_wdata;
         end
         if (rec_start) begin
            if (req_data.sample > max_ff) begin
               max_ff <= req_data.sample;
            end
            if ((min_ff == '0) || (req_data.sample < min_ff)) begin
               min_ff <= req_data.sample;
            end
            total_ff <= total_ff + lhp_pkg::DATA_W'(1);
         end
         if (state_ff == lhp_pkg::ST_EMIT) begin
            if (!rsp_valid_ff) begin
               rsp_valid_ff <= 1'b1;
            end else if (!rsp_stall && rsp_ff.last) begin
               rsp_valid_ff <= 1'b0;
            end
         end
      end
   end

   // walk datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         lhp_pkg::ST_DRAIN: begin
            len_ff <= len_in;
            k_ff   <= '0;
         end
         lhp_pkg::ST_PREP: begin
            thr_ff[k_ff[SIDX_W-1:0]] <= THR_W'(pct_ff[k_ff]) * THR_W'(total_ff);
            k_ff <= k_ff + lhp_pkg::SLOT_W'(1);
         end
         lhp_pkg::ST_READ: begin
            i_ff        <= '0;
            sum_ff      <= '0;
            j_ff        <= '0;
            last_cum_ff <= '0;
         end
         lhp_pkg::ST_ACC: begin
            sum_ff <= sum_ff + SUM_W'(ram_rd_data);
         end
         lhp_pkg::ST_SCALE: begin
            // times 1000 as 1024 - 32 + 8
            scaled_ff <= (SCALE_W'(sum_ff) << 10) - (SCALE_W'(sum_ff) << 5)
                       + (SCALE_W'(sum_ff) << 3);
         end
         lhp_pkg::ST_CHECK: begin
            if (reached) begin
               val_ff[j_ff[SIDX_W-1:0]] <= mid_value(i_ff);
               smp_ff[j_ff[SIDX_W-1:0]] <= seg_samples;
               last_cum_ff <= sum_ff[lhp_pkg::DATA_W-1:0];
               if (slot_last) begin
                  out_ff <= '0;
               end else begin
                  j_ff <= j_ff + lhp_pkg::SLOT_W'(1);
               end
            end else if (i_ff != LAST_BUCKET) begin
               i_ff <= i_ff + IDX_W'(1);
            end
         end
         lhp_pkg::ST_FILL: begin
            // slots never reached get value 0 and the samples not yet counted to a slot (zero for all but the first)
            val_ff[j_ff[SIDX_W-1:0]] <= '0;
            smp_ff[j_ff[SIDX_W-1:0]] <= seg_samples;
            last_cum_ff <= sum_ff[lhp_pkg::DATA_W-1:0];
            if (slot_last) begin
               out_ff <= '0;
            end else begin
               j_ff <= j_ff + lhp_pkg::SLOT_W'(1);
            end
         end
         lhp_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_ff <= rsp_next;
               out_ff <= out_sel;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
